@@ design/plob_pkg.sv @@
// ----------------------------------------------------------------------------
// Price level order book package
// Shared types and codes for the order book controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package plob_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_NF_EMPTY  = 3'd2;
    localparam logic [2:0] ST_NF_PASSED = 3'd3;
    localparam logic [2:0] ST_DROPPED   = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
        logic        top_changed;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture the input item
        logic execute;  // apply the captured operation to the tables
    } t_dp_cmd;

    // Datapath to controller: the table update is applied in the execute cycle,
    // so only a busy flag is returned.
    typedef struct packed {
        logic       busy;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/plob_if.sv @@
// ----------------------------------------------------------------------------
// Order book stream interface
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none

interface plob_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/price_level_order_book.sv @@
// An accepted item is captured at the transfer edge and executed in the S_EXEC
// state once the output register is free; the result is registered at execute.
// The controller alternates capture and execute, so no new item is taken until the
// last executes; execute waits while the output register holds an untaken result.
// Every slot of the selected table compares against the item in parallel.
// Reset (synchronous, active low) empties both tables and the last reported tops.
// ----------------------------------------------------------------------------
// Price level order book top level
// Connects the stream channels to the controller and the level table datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_order_book #(
    parameter int BOOK_DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    plob_if.sink      in_ch,
    plob_if.source    out_ch
);
    import plob_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_out_item w_out;
    logic     w_full, w_taken;

    // A transfer on the output side frees the result register.
    assign w_taken = out_ch.valid && out_ch.ready;

    plob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_taken(w_taken),
        .i_out_full (w_full),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // The datapath holds both tables; the captured item is applied in the
    // execute cycle and the result is registered at the same edge.
    plob_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (in_ch.data),
        .o_stat     (w_stat),
        .i_out_taken(w_taken),
        .o_out_full (w_full),
        .o_out      (w_out)
    );

    assign out_ch.valid = w_full;
    assign out_ch.data  = w_out;

endmodule

`default_nettype wire

@@ design/plob_ctrl.sv @@
// ----------------------------------------------------------------------------
// Order book controller
// Sequences capture, execution and result hand-off of one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_taken,
    input  wire logic              i_out_full,
    output plob_pkg::t_dp_cmd      o_cmd,
    input  wire plob_pkg::t_dp_stat i_stat
);
    import plob_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_out_free;

    // The execute cycle writes the output register, so it must be empty
    // or being emptied in that cycle.
    assign w_out_free = !i_out_full || i_out_taken;
    assign o_in_ready = (r_state == S_IDLE) && !i_stat.busy;

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.execute = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/plob_datapath.sv @@
// ----------------------------------------------------------------------------
// Order book datapath
// Two sorted level tables built as rows of cells, with per-slot compares.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_datapath #(
    parameter int BOOK_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire plob_pkg::t_dp_cmd   i_cmd,
    input  wire plob_pkg::t_in_item  i_item,
    output plob_pkg::t_dp_stat       o_stat,
    input  wire logic                i_out_taken,
    output logic                     o_out_full,
    output plob_pkg::t_out_item      o_out
);
    import plob_pkg::*;

    logic [31:0] r_bid_pr [BOOK_DEPTH];
    logic [31:0] r_ask_pr [BOOK_DEPTH];
    logic [31:0] r_bid_qt [BOOK_DEPTH];
    logic [31:0] r_ask_qt [BOOK_DEPTH];
    logic [31:0] r_last_bid, r_last_ask;
    t_in_item    r_item;
    t_out_item   r_out;
    logic        r_full;

    // Per slot flags on the selected side.
    logic [31:0] w_pr [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] w_empty, w_eq, w_worse, w_stop, w_ins_stop, w_ins_before;
    logic [BOOK_DEPTH-1:0] w_find_before, w_hit;
    logic        w_ask, w_any_stop, w_any_ins, w_dup, w_ins_ok, w_found, w_empty_stop;
    logic [31:0] w_new_pr [BOOK_DEPTH];
    logic [31:0] w_new_qt [BOOK_DEPTH];
    logic [2:0]  w_status;
    logic [31:0] w_bb, w_ba;

    assign w_ask = r_item.side;

    always_comb begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            w_pr[i]    = w_ask ? r_ask_pr[i] : r_bid_pr[i];
            w_empty[i] = (w_pr[i] == '0);
            w_eq[i]    = (w_pr[i] == r_item.price);
            // new price ranks strictly better than this slot
            w_worse[i] = w_ask ? (r_item.price < w_pr[i]) : (r_item.price > w_pr[i]);
            w_ins_stop[i] = w_empty[i] || w_worse[i];
            w_stop[i]     = w_empty[i] || w_eq[i] || w_worse[i];
        end
    end

    // Prefix flags: no stop at any earlier slot.
    always_comb begin
        w_ins_before[0]  = 1'b1;
        w_find_before[0] = 1'b1;
        for (int i = 1; i < BOOK_DEPTH; i++) begin
            w_ins_before[i]  = w_ins_before[i-1] && !w_ins_stop[i-1];
            w_find_before[i] = w_find_before[i-1] && !w_stop[i-1];
        end
    end

    always_comb begin
        w_any_ins    = |(w_ins_stop & w_ins_before);
        w_any_stop   = |(w_stop & w_find_before);
        w_hit        = w_find_before & w_eq & ~w_empty;
        w_found      = |w_hit;
        w_empty_stop = |(w_find_before & w_empty);
        w_dup        = |(w_ins_before & w_eq & ~w_empty);
        w_ins_ok     = (r_item.price != '0) && w_any_ins;
    end

    always_comb begin
        w_status = ST_OK;
        case (t_opcode'(r_item.opcode))
            OP_INSERT: w_status = !w_ins_ok ? ST_DROPPED : (w_dup ? ST_DUP : ST_OK);
            OP_UPDATE, OP_DELETE: begin
                if (!w_found)
                    w_status = (w_any_stop && w_empty_stop) ? ST_NF_EMPTY : ST_NF_PASSED;
            end
            default: w_status = ST_OK;
        endcase
    end

    // Next table contents for the selected side.
    always_comb begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            w_new_pr[i] = w_pr[i];
            w_new_qt[i] = w_ask ? r_ask_qt[i] : r_bid_qt[i];
            case (t_opcode'(r_item.opcode))
                OP_INSERT: begin
                    if (w_ins_ok) begin
                        if (w_ins_before[i] && w_ins_stop[i]) begin
                            w_new_pr[i] = r_item.price;
                            w_new_qt[i] = r_item.qty;
                        end else if (!w_ins_before[i] && i > 0) begin
                            w_new_pr[i] = w_ask ? r_ask_pr[(i>0)?i-1:0] : r_bid_pr[(i>0)?i-1:0];
                            w_new_qt[i] = w_ask ? r_ask_qt[(i>0)?i-1:0] : r_bid_qt[(i>0)?i-1:0];
                        end
                    end
                end
                OP_UPDATE: begin
                    if (w_hit[i]) w_new_qt[i] = r_item.qty;
                end
                OP_DELETE: begin
                    if (w_found && !w_find_before[i] || w_hit[i]) begin
                        if (i == BOOK_DEPTH-1) begin
                            w_new_pr[i] = '0;
                        end else begin
                            w_new_pr[i] = w_ask ? r_ask_pr[(i<BOOK_DEPTH-1)?i+1:i]
                                                : r_bid_pr[(i<BOOK_DEPTH-1)?i+1:i];
                            w_new_qt[i] = w_ask ? r_ask_qt[(i<BOOK_DEPTH-1)?i+1:i]
                                                : r_bid_qt[(i<BOOK_DEPTH-1)?i+1:i];
                        end
                    end
                end
                default: w_new_pr[i] = '0;
            endcase
        end
    end

    always_comb begin
        w_bb = r_bid_pr[0];
        w_ba = r_ask_pr[0];
        if (t_opcode'(r_item.opcode) == OP_CLEAR) begin
            w_bb = '0;
            w_ba = '0;
        end else if (w_ask) begin
            w_ba = w_new_pr[0];
        end else begin
            w_bb = w_new_pr[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.execute) begin
            for (int i = 0; i < BOOK_DEPTH; i++) begin
                if (w_ask || t_opcode'(r_item.opcode) == OP_CLEAR) r_ask_qt[i] <= w_new_qt[i];
                if (!w_ask || t_opcode'(r_item.opcode) == OP_CLEAR) r_bid_qt[i] <= w_new_qt[i];
            end
            r_out.status      <= w_status;
            r_out.best_bid    <= w_bb;
            r_out.best_ask    <= w_ba;
            r_out.top_changed <= (w_bb != r_last_bid) || (w_ba != r_last_ask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BOOK_DEPTH; i++) begin
                r_bid_pr[i] <= '0;
                r_ask_pr[i] <= '0;
            end
            r_last_bid <= '0;
            r_last_ask <= '0;
            r_full     <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                for (int i = 0; i < BOOK_DEPTH; i++) begin
                    if (t_opcode'(r_item.opcode) == OP_CLEAR) begin
                        r_bid_pr[i] <= '0;
                        r_ask_pr[i] <= '0;
                    end else if (w_ask) begin
                        r_ask_pr[i] <= w_new_pr[i];
                    end else begin
                        r_bid_pr[i] <= w_new_pr[i];
                    end
                end
                r_last_bid <= w_bb;
                r_last_ask <= w_ba;
                r_full     <= 1'b1;
            end else if (i_out_taken) begin
                r_full <= 1'b0;
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_full  = r_full;
    assign o_stat.busy = 1'b0;

endmodule

`default_nettype wire

@@ design/plob_checker.sv @@
// ----------------------------------------------------------------------------
// Order book port checker
// Watches the top level channels for result ordering and content rules.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  out_status,
    input wire logic        out_changed
);
    import plob_pkg::*;

    // The input is never ready in the cycle right after a transfer in.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !(in_ready))
        else $error("input taken in back-to-back cycles");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_status <= ST_DROPPED))
        else $error("status code out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
                                       && $stable(out_changed)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind price_level_order_book plob_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.data.status),
    .out_changed(out_ch.data.top_changed)
);

`default_nettype wire

@@ test/price_level_order_book_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Price level order book testbench
// Sends insert, update, delete and clear transfers through the input channel.
// Every result is checked against a behavioral copy of both level tables, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_order_book_tb;
    import plob_pkg::*;

    localparam int DEPTH = 16;

    logic i_clk;
    logic i_rst_n;

    plob_if #(.T(t_in_item))  in_ch ();
    plob_if #(.T(t_out_item)) out_ch ();

    price_level_order_book #(.BOOK_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Clock with a 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // The testbench's own copy of the book. Quantities are never reported,
    // so only the prices are kept.
    logic [31:0] bid_book [DEPTH];
    logic [31:0] ask_book [DEPTH];
    logic [31:0] shown_bid;
    logic [31:0] shown_ask;

    t_in_item  pending_orders [$];
    t_out_item expected_tops  [$];

    int  mismatch_count;
    int  result_count;
    int  sent_count;
    int  op_count [4];
    int  status_count [5];
    bit  no_idle;
    bit  hold_sender;

    // Strictly better price for the given side.
    function automatic bit ranks_above(input bit is_ask, input logic [31:0] a,
                                       input logic [31:0] b);
        return is_ask ? (a < b) : (a > b);
    endfunction

    // Applies one order to the book copy and returns the expected result.
    function automatic t_out_item apply_order(input t_in_item ord);
        logic [31:0] row [DEPTH];
        t_out_item   res;
        bit          is_ask;
        bit          dup;
        int          pos;
        int          hit;
        logic [2:0]  st;
        is_ask = ord.side;
        for (int i = 0; i < DEPTH; i++) begin
            row[i] = is_ask ? ask_book[i] : bid_book[i];
        end
        st = ST_OK;
        case (t_opcode'(ord.opcode))
            OP_INSERT: begin
                dup = 1'b0;
                pos = DEPTH;
                if (ord.price == 32'd0) begin
                    st = ST_DROPPED;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (row[i] == 32'd0) begin
                            pos = i;
                            break;
                        end
                        if (row[i] == ord.price) dup = 1'b1;
                        if (ranks_above(is_ask, ord.price, row[i])) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= DEPTH) begin
                        st = ST_DROPPED;
                    end else begin
                        for (int i = DEPTH - 1; i > pos; i--) row[i] = row[i - 1];
                        row[pos] = ord.price;
                        st = dup ? ST_DUP : ST_OK;
                    end
                end
            end
            OP_UPDATE, OP_DELETE: begin
                hit = -1;
                st  = ST_NF_PASSED;
                for (int i = 0; i < DEPTH; i++) begin
                    if (row[i] == 32'd0) begin
                        st = ST_NF_EMPTY;
                        break;
                    end
                    if (row[i] == ord.price) begin
                        hit = i;
                        st  = ST_OK;
                        break;
                    end
                    if (ranks_above(is_ask, ord.price, row[i])) break;
                end
                if (hit >= 0 && t_opcode'(ord.opcode) == OP_DELETE) begin
                    for (int i = hit; i < DEPTH - 1; i++) row[i] = row[i + 1];
                    row[DEPTH - 1] = 32'd0;
                end
            end
            default: begin
                for (int i = 0; i < DEPTH; i++) begin
                    row[i]      = 32'd0;
                    bid_book[i] = 32'd0;
                    ask_book[i] = 32'd0;
                end
            end
        endcase
        if (t_opcode'(ord.opcode) != OP_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (is_ask) ask_book[i] = row[i];
                else        bid_book[i] = row[i];
            end
        end
        res.status      = st;
        res.best_bid    = bid_book[0];
        res.best_ask    = ask_book[0];
        res.top_changed = (bid_book[0] != shown_bid) || (ask_book[0] != shown_ask);
        shown_bid = bid_book[0];
        shown_ask = ask_book[0];
        return res;
    endfunction

    function automatic t_in_item make_order(input t_opcode op, input bit side,
                                            input logic [31:0] price,
                                            input logic [31:0] qty);
        t_in_item ord;
        ord.opcode = op;
        ord.side   = side;
        ord.price  = price;
        ord.qty    = qty;
        return ord;
    endfunction

    // Picks a price near a small center so that duplicates and hits are common,
    // with occasional zero and full-range values to toggle every bit.
    function automatic logic [31:0] pick_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'd0;
        if (r < 10) return $urandom;
        if (r < 13) return 32'hFFFF_FFFF;
        return 32'd1000 + $urandom_range(0, 40);
    endfunction

    // Driver: presents the oldest pending order, idling at random unless held
    // back or in the stretch with no idle cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_tops.push_back(apply_order(in_ch.data));
                op_count[in_ch.data.opcode]++;
                sent_count++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Keep the current transfer on the channel.
            end else if (!hold_sender && pending_orders.size() > 0
                         && (no_idle || $urandom_range(0, 99) >= 29)) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_orders.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: takes results with random stalls and compares every field.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                result_count++;
                if (expected_tops.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected result %p", out_ch.data);
                end else begin
                    want = expected_tops.pop_front();
                    if (out_ch.data !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: result %0d expected %p got %p",
                                     result_count, want, out_ch.data);
                    end else begin
                        status_count[want.status]++;
                    end
                end
            end
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 29);
        end
    end

    task automatic wait_drained();
        while (pending_orders.size() > 0 || in_ch.valid || expected_tops.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int          r;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        sent_count     = 0;
        no_idle        = 1'b0;
        hold_sender    = 1'b0;
        shown_bid      = 32'd0;
        shown_ask      = 32'd0;
        foreach (op_count[i]) op_count[i] = 0;
        foreach (status_count[i]) status_count[i] = 0;
        for (int i = 0; i < DEPTH; i++) begin
            bid_book[i] = 32'd0;
            ask_book[i] = 32'd0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-book misses, extreme prices, duplicates, zero
        // price, delete and clear.
        pending_orders.push_back(make_order(OP_UPDATE, 1'b0, 32'd5, 32'd1));
        pending_orders.push_back(make_order(OP_DELETE, 1'b1, 32'd5, 32'd0));
        pending_orders.push_back(make_order(OP_INSERT, 1'b0, 32'd0, 32'hFFFF_FFFF));
        pending_orders.push_back(make_order(OP_INSERT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_orders.push_back(make_order(OP_INSERT, 1'b1, 32'd1, 32'd0));
        pending_orders.push_back(make_order(OP_INSERT, 1'b0, 32'd100, 32'd7));
        pending_orders.push_back(make_order(OP_INSERT, 1'b0, 32'd100, 32'd8));
        pending_orders.push_back(make_order(OP_INSERT, 1'b1, 32'd200, 32'd9));
        pending_orders.push_back(make_order(OP_UPDATE, 1'b0, 32'd100, 32'h5555_AAAA));
        pending_orders.push_back(make_order(OP_UPDATE, 1'b0, 32'd150, 32'd1));
        pending_orders.push_back(make_order(OP_UPDATE, 1'b0, 32'd50, 32'd1));
        pending_orders.push_back(make_order(OP_DELETE, 1'b1, 32'd1, 32'd0));
        pending_orders.push_back(make_order(OP_DELETE, 1'b1, 32'd150, 32'd0));
        pending_orders.push_back(make_order(OP_DELETE, 1'b0, 32'hFFFF_FFFF, 32'd0));
        pending_orders.push_back(make_order(OP_CLEAR, 1'b0, 32'd0, 32'd0));
        // Fill the ask side past full, then one worse than the full table.
        for (int i = 0; i < DEPTH + 2; i++)
            pending_orders.push_back(make_order(OP_INSERT, 1'b1, 32'd10 + i, i));
        pending_orders.push_back(make_order(OP_INSERT, 1'b1, 32'd500, 32'd1));
        pending_orders.push_back(make_order(OP_UPDATE, 1'b1, 32'd500, 32'd1));
        pending_orders.push_back(make_order(OP_INSERT, 1'b1, 32'd5, 32'd1));
        wait_drained();

        // Hold the sender until every expected result has come.
        hold_sender = 1'b1;
        wait_drained();
        hold_sender = 1'b0;

        // Random part: half inserts around a fixed center so tables fill,
        // with hits and misses for update and delete, and rare clears.
        for (int n = 0; n < 600; n++) begin
            if (n == 200) begin
                wait_drained();
                no_idle = 1'b1;
            end
            if (n == 320) begin
                wait_drained();
                no_idle = 1'b0;
            end
            r = $urandom_range(0, 99);
            pending_orders.push_back(make_order(
                r < 50 ? OP_INSERT : r < 70 ? OP_UPDATE : r < 97 ? OP_DELETE : OP_CLEAR,
                $urandom_range(0, 1), pick_price(), $urandom));
        end
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d transfers: %0d insert, %0d update, %0d delete, %0d clear.",
                 sent_count, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Statuses seen: ok %0d, dup %0d, empty %0d, passed %0d, dropped %0d.",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 status_count[4]);
        if (mismatch_count == 0 && expected_tops.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Safety limit far above the slowest correct run.
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
